>>> sv/ssas_pkg.sv
// ============================================================================
// ssas_pkg - shared types and constants
// Item layouts, operation codes and controller/datapath command and status
// for the sorted scored attribute set.
// ============================================================================
package ssas_pkg;

    // Fixed field widths
    localparam int ID_W     = 16;
    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 24;
    localparam int COUNT_W  = 6;

    // A matched term scores its stored weight times two
    localparam int MATCH_SHIFT = 1;
    localparam int SC_W        = WEIGHT_W + MATCH_SHIFT;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = '1;
    localparam logic [SCORE_W-1:0]  SCORE_MAX      = '1;
    localparam logic [ID_W-1:0]     WILDCARD_RESET = 16'd1;

    // Item kinds
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_SCORE  = 2'd3;

    // Datapath commands
    typedef logic [3:0] op_t;
    localparam op_t CMD_NONE   = 4'd0;
    localparam op_t CMD_START  = 4'd1;
    localparam op_t CMD_SCAN   = 4'd2;
    localparam op_t CMD_DECIDE = 4'd3;
    localparam op_t CMD_SHUP   = 4'd4;
    localparam op_t CMD_SHDN   = 4'd5;
    localparam op_t CMD_DRAIN  = 4'd6;
    localparam op_t CMD_PUTNEW = 4'd7;
    localparam op_t CMD_LOAD   = 4'd8;

    // Follow-up action decided for an item
    typedef logic [1:0] act_t;
    localparam act_t ACT_NONE = 2'd0;
    localparam act_t ACT_UP   = 2'd1;
    localparam act_t ACT_DN   = 2'd2;
    localparam act_t ACT_PUT  = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ID_W-1:0]     attr_id;
        logic [WEIGHT_W-1:0] weight;
        logic                last_term;
    } in_item_t;

    typedef struct packed {
        logic                ok;
        logic                found;
        logic [WEIGHT_W-1:0] entry_weight;
        logic [SCORE_W-1:0]  total_score;
        logic [COUNT_W-1:0]  entry_count;
        logic                done_res;
    } out_item_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic scan_done;
        act_t act;
        logic shift_last;
        logic shift_up;
        logic out_free;
    } sts_t;

endpackage

>>> sv/ssas_in_if.sv
// ============================================================================
// ssas_in_if - input item channel
// Valid/ready channel carrying one request beat.
// ============================================================================
interface ssas_in_if
    import ssas_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ssas_out_if.sv
// ============================================================================
// ssas_out_if - result item channel
// Valid/ready channel carrying one result beat.
// ============================================================================
interface ssas_out_if
    import ssas_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ssas_ctrl.sv
// ============================================================================
// ssas_ctrl - sequencer
// Steps one item through scan, decide, shift, insert and result load.
// ============================================================================
module ssas_ctrl
    import ssas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SHUP   = 3'd3;
    localparam logic [2:0] ST_SHDN   = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_PUTNEW = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_START;
                    state_next = sts.fill_zero ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.op = CMD_SCAN;
                if (sts.scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.op = CMD_DECIDE;
                case (sts.act)
                    ACT_UP:  state_next = ST_SHUP;
                    ACT_DN:  state_next = ST_SHDN;
                    ACT_PUT: state_next = ST_PUTNEW;
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_SHUP:
            begin
                cmd.op = CMD_SHUP;
                if (sts.shift_last)
                    state_next = ST_DRAIN;
            end
            ST_SHDN:
            begin
                cmd.op = CMD_SHDN;
                if (sts.shift_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cmd.op     = CMD_DRAIN;
                state_next = sts.shift_up ? ST_PUTNEW : ST_RESULT;
            end
            ST_PUTNEW:
            begin
                cmd.op     = CMD_PUTNEW;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/ssas_dp.sv
// ============================================================================
// ssas_dp - datapath
// Entry memory, scan compare, shift pipeline, weight and score arithmetic,
// wildcard register and result register.
// ============================================================================
module ssas_dp
    import ssas_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int ATTR_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [ID_W-1:0] cfg_wdata,
    input  in_item_t        in_item,
    output out_item_t       out_item,
    output logic            out_valid,
    input  logic            out_ready,
    input  cmd_t            cmd,
    output sts_t            sts
);

    localparam int KEY_W = (ATTR_BITS < ID_W) ? ATTR_BITS : ID_W;
    localparam int ENT_W = KEY_W + WEIGHT_W;
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Entry memory: {id, weight}, sorted by id
    logic [ENT_W-1:0] ent_mem [CAPACITY];
    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    // Control state
    logic [ID_W-1:0]    wild_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [SCORE_W-1:0] run_reg;
    logic               failed_reg;
    logic               sh_vld_reg;
    logic               out_vld_reg;

    // Item and working registers
    logic [1:0]          kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [WEIGHT_W-1:0] wt_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                hit_reg;
    logic [WEIGHT_W-1:0] hw_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       end_reg;
    logic                dir_up_reg;
    logic [AW-1:0]       sh_addr_reg;
    logic                res_ok_reg;
    logic                res_found_reg;
    logic [WEIGHT_W-1:0] res_wout_reg;
    logic [SCORE_W-1:0]  res_total_reg;
    logic                res_done_reg;
    out_item_t           out_reg;

    // Decide-step values
    logic [KEY_W-1:0]    rd_id;
    logic [WEIGHT_W-1:0] rd_wt;
    logic                id_ge;
    logic                is_add;
    logic                real_add;
    logic                full;
    logic                ins;
    logic                more_after;
    logic [WEIGHT_W:0]   wsum;
    logic [WEIGHT_W-1:0] wsat;
    logic [WEIGHT_W-1:0] hit_wt;
    logic [WEIGHT_W-1:0] wout;
    act_t                act;
    logic [SC_W-1:0]     sc;
    logic [SCORE_W:0]    ssum;
    logic [SCORE_W-1:0]  run_next;
    logic                failed_next;
    logic [SCORE_W-1:0]  total_next;

    // Scan compare on the entry just read
    assign rd_id = rd_data_reg[ENT_W-1:WEIGHT_W];
    assign rd_wt = rd_data_reg[WEIGHT_W-1:0];
    assign id_ge = (rd_id >= key_reg);

    // Outcome of the located item
    always_comb
    begin
        is_add     = (kind_reg == KIND_ADD);
        real_add   = is_add && (key_reg != '0) && (wt_reg != '0);
        full       = (fill_reg == CNT_W'(CAPACITY));
        ins        = real_add && !hit_reg && !full;
        more_after = (({1'b0, idx_reg} + 1'b1) < {1'b0, fill_reg});
        wsum       = {1'b0, hw_reg} + {1'b0, wt_reg};
        wsat       = wsum[WEIGHT_W] ? WEIGHT_MAX : wsum[WEIGHT_W-1:0];
        hit_wt     = hit_reg ? hw_reg : '0;

        act = ACT_NONE;
        if (ins)
            act = (idx_reg < fill_reg) ? ACT_UP : ACT_PUT;
        else if ((kind_reg == KIND_REMOVE) && hit_reg && more_after)
            act = ACT_DN;

        wout = hit_wt;
        if (real_add)
        begin
            if (hit_reg)
                wout = wsat;
            else if (full)
                wout = '0;
            else
                wout = wt_reg;
        end
        else if (kind_reg == KIND_REMOVE)
        begin
            wout = '0;
        end

        // Term score: wildcard takes its own weight, a match twice the stored one
        if (fill_reg == '0)
            sc = '0;
        else if (key_reg == wild_reg[KEY_W-1:0])
            sc = SC_W'(wt_reg);
        else if (hit_reg)
            sc = SC_W'(hw_reg) << MATCH_SHIFT;
        else
            sc = '0;

        ssum = {1'b0, run_reg} + (SCORE_W + 1)'(sc);
        if (sc == '0)
        begin
            failed_next = 1'b1;
            run_next    = '0;
        end
        else if (!failed_reg)
        begin
            failed_next = 1'b0;
            run_next    = ssum[SCORE_W] ? SCORE_MAX : ssum[SCORE_W-1:0];
        end
        else
        begin
            failed_next = 1'b1;
            run_next    = run_reg;
        end
        total_next = failed_next ? '0 : run_next;
    end

    // Memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = {key_reg, wt_reg};
        case (cmd.op)
            CMD_START:
            begin
                rd_en = 1'b1;
            end
            CMD_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg + 1'b1);
            end
            CMD_DECIDE:
            begin
                if (real_add && hit_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = {key_reg, wsat};
                end
            end
            CMD_SHUP, CMD_SHDN, CMD_DRAIN:
            begin
                rd_en   = (cmd.op != CMD_DRAIN);
                rd_addr = ptr_reg;
                if (sh_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dir_up_reg ? (sh_addr_reg + AW'(1)) : (sh_addr_reg - AW'(1));
                    wr_data = rd_data_reg;
                end
            end
            CMD_PUTNEW:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ent_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= ent_mem[rd_addr];
    end

    // Status to the sequencer
    always_comb
    begin
        sts.fill_zero  = (fill_reg == '0);
        sts.scan_done  = id_ge || (CNT_W'(idx_reg + 1'b1) == fill_reg);
        sts.act        = act;
        sts.shift_last = (ptr_reg == end_reg);
        sts.shift_up   = dir_up_reg;
        sts.out_free   = !out_vld_reg || out_ready;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wild_reg    <= WILDCARD_RESET;
            fill_reg    <= '0;
            run_reg     <= '0;
            failed_reg  <= 1'b0;
            sh_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                wild_reg <= cfg_wdata;

            if (cmd.op == CMD_DECIDE)
            begin
                if (ins)
                    fill_reg <= fill_reg + 1'b1;
                else if ((kind_reg == KIND_REMOVE) && hit_reg)
                    fill_reg <= fill_reg - 1'b1;

                if (kind_reg == KIND_SCORE)
                begin
                    run_reg    <= last_reg ? '0 : run_next;
                    failed_reg <= last_reg ? 1'b0 : failed_next;
                end
            end

            // Shift pipeline: one read in flight, written back in the next cycle
            if ((cmd.op == CMD_SHUP) || (cmd.op == CMD_SHDN))
                sh_vld_reg <= 1'b1;
            else if (cmd.op == CMD_DRAIN)
                sh_vld_reg <= 1'b0;

            if (cmd.op == CMD_LOAD)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Item, scan and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_START:
            begin
                kind_reg <= in_item.kind;
                key_reg  <= in_item.attr_id[KEY_W-1:0];
                wt_reg   <= in_item.weight;
                last_reg <= in_item.last_term;
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                hw_reg   <= '0;
            end
            CMD_SCAN:
            begin
                if (id_ge)
                begin
                    hit_reg <= (rd_id == key_reg);
                    hw_reg  <= rd_wt;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            CMD_DECIDE:
            begin
                res_ok_reg    <= !(real_add && !hit_reg && full);
                res_found_reg <= hit_reg;
                res_wout_reg  <= wout;
                res_total_reg <= (kind_reg == KIND_SCORE) ? total_next : '0;
                res_done_reg  <= (kind_reg == KIND_SCORE) && last_reg;
                if (act == ACT_DN)
                begin
                    dir_up_reg <= 1'b0;
                    ptr_reg    <= AW'(idx_reg + 1'b1);
                    end_reg    <= AW'(fill_reg - 1'b1);
                end
                else
                begin
                    dir_up_reg <= (act == ACT_UP);
                    ptr_reg    <= AW'(fill_reg - 1'b1);
                    end_reg    <= idx_reg[AW-1:0];
                end
            end
            CMD_SHUP:
            begin
                sh_addr_reg <= ptr_reg;
                ptr_reg     <= ptr_reg - AW'(1);
            end
            CMD_SHDN:
            begin
                sh_addr_reg <= ptr_reg;
                ptr_reg     <= ptr_reg + AW'(1);
            end
            CMD_LOAD:
            begin
                out_reg.ok           <= res_ok_reg;
                out_reg.found        <= res_found_reg;
                out_reg.entry_weight <= res_wout_reg;
                out_reg.total_score  <= res_total_reg;
                out_reg.entry_count  <= COUNT_W'(fill_reg);
                out_reg.done_res     <= res_done_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_item  = out_reg;
    assign out_valid = out_vld_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_LOAD) |=> out_vld_reg)
        else $error("loaded result not presented");

    a_shift_pending: assert property (@(posedge clk) disable iff (!rst_n)
        sh_vld_reg |-> ((cmd.op == CMD_SHUP) || (cmd.op == CMD_SHDN) ||
                        (cmd.op == CMD_DRAIN)))
        else $error("pending shift write dropped");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == CMD_DECIDE) && (act == ACT_UP || act == ACT_PUT)) |=>
        (fill_reg == CNT_W'($past(fill_reg) + 1'b1)))
        else $error("insert did not grow the set");

endmodule

>>> sv/sorted_scored_attribute_set_core.sv
// Throughput: one item at a time; the entry memory moves one entry per cycle for the
//   ordered scan and for the shift that opens or closes a gap.
// Reset: asynchronous, active low; empties the set, clears the query, wildcard id = 1.
// ============================================================================
// sorted_scored_attribute_set_core - top level
// Sorted (id, weight) set with add, remove, lookup and query scoring.
// ============================================================================
module sorted_scored_attribute_set_core
    import ssas_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int ATTR_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [ID_W-1:0] cfg_wdata,
    ssas_in_if.sink         req,
    ssas_out_if.source      rsp
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    ssas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssas_dp #(
        .CAPACITY  (CAPACITY),
        .ATTR_BITS (ATTR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (req.data),
        .out_item  (rsp.data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
